// ===== src/pptu_pkg.sv =====
// shared types, constants and microcode for the particle pool tick update block
`timescale 1ns / 1ps
`default_nettype none
package pptu_pkg;

  localparam int PARTICLES = 64;
  localparam int SLOT_W    = 6;
  localparam int POS_W     = 31;
  localparam int VEL_W     = 10;
  localparam int LIFE_W    = 6;
  localparam int RAND_W    = 7;
  localparam int IDX_W     = 2;

  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(PARTICLES - 1);
  localparam logic [LIFE_W-1:0] LIFE_START = LIFE_W'(60);
  localparam logic [VEL_W-1:0]  VEL_OFFSET = VEL_W'(50);
  localparam logic [VEL_W-1:0]  GRAVITY    = VEL_W'(5);

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_EMITTER_X = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_EMITTER_Y = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_EMITTER_Z = IDX_W'(2);

  typedef struct packed {
    logic [LIFE_W-1:0]       life;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
  } entry_t;

  typedef struct packed {
    logic signed [POS_W-1:0] emitter_x;
    logic signed [POS_W-1:0] emitter_y;
    logic signed [POS_W-1:0] emitter_z;
    logic [RAND_W-1:0]       rand_x;
    logic [RAND_W-1:0]       rand_y;
    logic [RAND_W-1:0]       rand_z;
  } spawn_src_t;

  // microcode
  localparam int PC_W = 1;

  typedef enum logic [0:0] {
    COND_TICK_IN  = 1'b0,
    COND_WALK_END = 1'b1
  } cond_t;

  typedef struct packed {
    logic             wait_in;
    logic             walk;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctrl_word_t;

  localparam logic [PC_W-1:0] PC_IDLE = PC_W'(0);
  localparam logic [PC_W-1:0] PC_WALK = PC_W'(1);

  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      PC_IDLE: w = '{wait_in: 1'b1, walk: 1'b0, cond: COND_TICK_IN,  target: PC_WALK};
      PC_WALK: w = '{wait_in: 1'b0, walk: 1'b1, cond: COND_WALK_END, target: PC_IDLE};
      default: w = '{wait_in: 1'b1, walk: 1'b0, cond: COND_TICK_IN,  target: PC_WALK};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== src/pptu_if.sv =====
// channel interfaces: tick input, result output, configuration write
`timescale 1ns / 1ps
`default_nettype none
interface pptu_in_if;
  logic                            valid;
  logic                            ready;
  logic [pptu_pkg::RAND_W-1:0]     rand_x;
  logic [pptu_pkg::RAND_W-1:0]     rand_y;
  logic [pptu_pkg::RAND_W-1:0]     rand_z;
  modport source (output valid, rand_x, rand_y, rand_z, input ready);
  modport sink   (input valid, rand_x, rand_y, rand_z, output ready);
endinterface

interface pptu_out_if;
  logic                               valid;
  logic                               ready;
  logic [pptu_pkg::SLOT_W-1:0]        slot;
  logic signed [pptu_pkg::POS_W-1:0]  out_x;
  logic signed [pptu_pkg::POS_W-1:0]  out_y;
  logic signed [pptu_pkg::POS_W-1:0]  out_z;
  logic [pptu_pkg::LIFE_W-1:0]        life_left;
  logic                               expired;
  logic                               spawned;
  logic                               last;
  modport source (output valid, slot, out_x, out_y, out_z, life_left, expired, spawned, last,
                  input ready);
  modport sink   (input valid, slot, out_x, out_y, out_z, life_left, expired, spawned, last,
                  output ready);
endinterface

interface pptu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pptu_pkg::IDX_W-1:0]        index;
  logic signed [pptu_pkg::POS_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/particle_pool_tick_update_core.sv =====
// top level: particle pool tick update with microcoded slot walk
//
// Each accepted tick spawns one particle into the lowest free slot (if any) and
// updates every live particle in slot order, one result per live slot, with
// last set on the final one. The idle step takes the tick; the sequencer then
// walks the slot counter over every pool slot of the particle memory, reading
// the next slot while writing the current one. A live slot, or the free slot
// that takes the spawn, waits while the result register is full and not taken;
// other free slots pass without waiting. The result of the previous tick may
// still sit in the output register while the next tick is taken. Emitter
// registers may be written at any time the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module particle_pool_tick_update_core (
  input  wire logic    clk,
  input  wire logic    rst,
  pptu_in_if.sink      tick,
  pptu_out_if.source   result,
  pptu_cfg_if.sink     cfg
);

  logic [pptu_pkg::PC_W-1:0]       pc;
  logic [pptu_pkg::PC_W-1:0]       pc_next;
  pptu_pkg::ctrl_word_t            cw;
  logic [pptu_pkg::SLOT_W-1:0]     slot;
  logic [pptu_pkg::SLOT_W-1:0]     rd_addr;
  logic                            spawn_done;
  logic [pptu_pkg::PARTICLES-1:0]  alive;
  pptu_pkg::spawn_src_t            src;
  pptu_pkg::entry_t                mem [pptu_pkg::PARTICLES];
  pptu_pkg::entry_t                rdata;
  pptu_pkg::entry_t                upd;

  logic tick_fire;
  logic spawn_here;
  logic active;
  logic advance;
  logic cond_true;
  logic alive_above;
  logic is_last;
  logic [pptu_pkg::PARTICLES-1:0] above;

  assign cw        = pptu_pkg::ucode(pc);
  assign tick.ready = cw.wait_in;
  assign tick_fire = tick.valid && tick.ready;
  assign cfg.ready = 1'b1;

  // configuration and tick capture
  always_ff @(posedge clk) begin
    if (rst) begin
      src.emitter_x <= '0;
      src.emitter_y <= '0;
      src.emitter_z <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          pptu_pkg::REG_EMITTER_X: src.emitter_x <= cfg.data;
          pptu_pkg::REG_EMITTER_Y: src.emitter_y <= cfg.data;
          pptu_pkg::REG_EMITTER_Z: src.emitter_z <= cfg.data;
          default: ;
        endcase
      end
      if (tick_fire) begin
        src.rand_x <= tick.rand_x;
        src.rand_y <= tick.rand_y;
        src.rand_z <= tick.rand_z;
      end
    end
  end

  // slot status
  assign spawn_here  = cw.walk && !spawn_done && !alive[slot];
  assign active      = cw.walk && (alive[slot] || spawn_here);
  assign advance     = !(active && result.valid && !result.ready);
  assign above       = (alive >> slot) >> 1;
  assign alive_above = |above;
  // a pending spawn lands in a free slot above this one
  assign is_last     = !alive_above &&
                       !(!spawn_done && alive[slot] && slot != pptu_pkg::LAST_SLOT);

  always_comb begin
    case (cw.cond)
      pptu_pkg::COND_TICK_IN:  cond_true = tick_fire;
      pptu_pkg::COND_WALK_END: cond_true = advance && slot == pptu_pkg::LAST_SLOT;
      default:                 cond_true = 1'b0;
    endcase
  end

  assign pc_next = cond_true ? cw.target : pc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= pptu_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot       <= '0;
      spawn_done <= 1'b0;
      alive      <= '0;
    end else if (cw.wait_in) begin
      slot <= '0;
      if (tick_fire) begin
        spawn_done <= 1'b0;
      end
    end else if (cw.walk && advance) begin
      slot <= slot + pptu_pkg::SLOT_W'(1);
      if (spawn_here) begin
        spawn_done <= 1'b1;
      end
      if (active) begin
        alive[slot] <= (upd.life != '0);
      end
    end
  end

  // particle memory: read the slot that comes up next, write the current one
  always_comb begin
    if (cw.walk && advance) begin
      rd_addr = slot + pptu_pkg::SLOT_W'(1);
    end else if (cw.walk) begin
      rd_addr = slot;
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (active && advance) begin
      mem[slot] <= upd;
    end
  end

  pptu_alu u_alu (
    .spawn (spawn_here),
    .src   (src),
    .cur   (rdata),
    .upd   (upd)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (active && advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (active && advance) begin
      result.slot      <= slot;
      result.out_x     <= upd.pos_x;
      result.out_y     <= upd.pos_y;
      result.out_z     <= upd.pos_z;
      result.life_left <= upd.life;
      result.expired   <= (upd.life == '0);
      result.spawned   <= spawn_here;
      result.last      <= is_last;
    end
  end

endmodule
`default_nettype wire

// ===== src/pptu_alu.sv =====
// per-slot update datapath: spawn init, gravity, saturating move, life countdown
`timescale 1ns / 1ps
`default_nettype none
module pptu_alu (
  input  wire logic                 spawn,
  input  wire pptu_pkg::spawn_src_t src,
  input  wire pptu_pkg::entry_t     cur,
  output pptu_pkg::entry_t          upd
);

  pptu_pkg::entry_t              base;
  logic [pptu_pkg::VEL_W-1:0]    rx;
  logic [pptu_pkg::VEL_W-1:0]    ry;
  logic [pptu_pkg::VEL_W-1:0]    rz;
  logic signed [pptu_pkg::VEL_W-1:0] vy;

  function automatic logic signed [pptu_pkg::POS_W-1:0] sat_add(
    input logic signed [pptu_pkg::POS_W-1:0] p,
    input logic signed [pptu_pkg::VEL_W-1:0] v
  );
    logic signed [pptu_pkg::POS_W:0] s;
    logic signed [pptu_pkg::POS_W-1:0] r;
    s = {p[pptu_pkg::POS_W-1], p} + (pptu_pkg::POS_W+1)'(v);
    if (s[pptu_pkg::POS_W] == s[pptu_pkg::POS_W-1]) begin
      r = s[pptu_pkg::POS_W-1:0];
    end else if (s[pptu_pkg::POS_W]) begin
      r = {1'b1, {(pptu_pkg::POS_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(pptu_pkg::POS_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign rx = pptu_pkg::VEL_W'(src.rand_x);
  assign ry = pptu_pkg::VEL_W'(src.rand_y);
  assign rz = pptu_pkg::VEL_W'(src.rand_z);

  always_comb begin
    if (spawn) begin
      base.life  = pptu_pkg::LIFE_START;
      base.pos_x = src.emitter_x;
      base.pos_y = src.emitter_y;
      base.pos_z = src.emitter_z;
      base.vel_x = rx - pptu_pkg::VEL_OFFSET;
      base.vel_y = ry + pptu_pkg::VEL_OFFSET;
      base.vel_z = rz - pptu_pkg::VEL_OFFSET;
    end else begin
      base = cur;
    end
  end

  assign vy = base.vel_y - pptu_pkg::GRAVITY;

  always_comb begin
    upd.vel_x = base.vel_x;
    upd.vel_y = vy;
    upd.vel_z = base.vel_z;
    upd.pos_x = sat_add(base.pos_x, base.vel_x);
    upd.pos_y = sat_add(base.pos_y, vy);
    upd.pos_z = sat_add(base.pos_z, base.vel_z);
    upd.life  = (base.life == '0) ? '0 : base.life - pptu_pkg::LIFE_W'(1);
  end

endmodule
`default_nettype wire
